/* src/tsmf_pkg.sv */
package tsmf_pkg;

    localparam int WINDOW   = 8;
    localparam int CHANNELS = 6;
    localparam int MIN_FILL = 3;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int FILT_W   = 24;
    localparam int Q_SHIFT  = 8;

    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int TRIM_W   = SUM_W + 1;
    localparam int NUM_W    = TRIM_W + Q_SHIFT;
    localparam int STEP_W   = $clog2(NUM_W);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [NUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [FILT_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* src/tsmf_stats.sv */
module tsmf_stats (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [tsmf_pkg::ADDR_W-1:0]         i_wr_addr,
    input  logic [tsmf_pkg::SAMPLE_W-1:0]       i_wr_data,
    input  logic                                i_rd_en,
    input  logic                                i_rd_first,
    input  logic [tsmf_pkg::ADDR_W-1:0]         i_rd_addr,
    output logic signed [tsmf_pkg::SUM_W-1:0]   o_sum,
    output logic signed [tsmf_pkg::SAMPLE_W-1:0] o_lo,
    output logic signed [tsmf_pkg::SAMPLE_W-1:0] o_hi
);

    logic [tsmf_pkg::SAMPLE_W-1:0]        r_mem [tsmf_pkg::DEPTH];
    logic signed [tsmf_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                                 r_rd_vld;
    logic                                 r_rd_first;
    logic signed [tsmf_pkg::SUM_W-1:0]    r_sum;
    logic signed [tsmf_pkg::SAMPLE_W-1:0] r_lo;
    logic signed [tsmf_pkg::SAMPLE_W-1:0] r_hi;
    logic signed [tsmf_pkg::SUM_W-1:0]    rd_ext;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_first <= i_rd_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign rd_ext = {{(tsmf_pkg::SUM_W - tsmf_pkg::SAMPLE_W){r_rd_data[tsmf_pkg::SAMPLE_W-1]}},
                     r_rd_data};

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_first) begin
                r_sum <= rd_ext;
                r_lo  <= r_rd_data;
                r_hi  <= r_rd_data;
            end else begin
                r_sum <= r_sum + rd_ext;
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end
    end

    assign o_sum = r_sum;
    assign o_lo  = r_lo;
    assign o_hi  = r_hi;

endmodule

/* src/tsmf_div.sv */
module tsmf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsmf_pkg::t_div_req i_req,
    output tsmf_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [tsmf_pkg::STEP_W-1:0]     r_step;
    logic [tsmf_pkg::CNT_W-1:0]      r_rem;
    logic [tsmf_pkg::NUM_W-1:0]      r_quo;
    logic [tsmf_pkg::CNT_W-1:0]      r_div;
    logic                            r_neg;
    logic [tsmf_pkg::CNT_W:0]        rem_sh;
    logic                            ge;
    logic [tsmf_pkg::CNT_W:0]        rem_sub;
    logic                            last;
    logic [tsmf_pkg::FILT_W-1:0]     mag;

    assign rem_sh  = {r_rem, r_quo[tsmf_pkg::NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign last    = r_step == tsmf_pkg::STEP_W'(tsmf_pkg::NUM_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[tsmf_pkg::CNT_W-1:0] : rem_sh[tsmf_pkg::CNT_W-1:0];
            r_quo <= {r_quo[tsmf_pkg::NUM_W-2:0], ge};
        end
    end

    assign mag             = r_quo[tsmf_pkg::FILT_W-1:0];
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_neg ? (~mag + 1'b1) : mag;

endmodule

/* src/trimmed_sliding_mean_filter.sv */
// Trimmed moving-average filter over a per-channel window of recent samples.
// Input requests arrive on the slave stream: tdata carries the signed 16-bit
// sample in bits 15:0 and the channel number in bits 18:16. Each in-range
// request is stored in its channel's circular window. Once at least three
// samples are held, the result is the mean of the window with one largest and
// one smallest sample removed, in signed Q8, truncated toward zero.
// Otherwise, and for channels at or above the channel count, the sample is
// returned times 256. The master stream carries the 24-bit result in tdata and
// a flag in tuser that is set when a trimmed mean was computed.
// One request is processed at a time. A pass-through result is loaded into the
// output register in the ST_OUT state. An averaged result takes these steps:
// one memory read per stored sample, the drain and start states to finish the
// sums, then a radix-2 divider that resolves one of its 28 quotient bits per
// cycle, and last the quotient is taken into the result register.
// The next request is accepted once a result enters the output register, even
// while that result still waits there. If the receiver stalls, the next
// finished result is held until the output register frees.
// Reset empties every window at once; no clearing pass is needed.
module trimmed_sliding_mean_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // sample[15:0], channel[18:16], zero[23:19]
    input  logic [tsmf_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // filtered[23:0]
    output logic [tsmf_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // averaged[0]
    output logic                                o_m_tuser
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state                               r_state, n_state;
    logic [tsmf_pkg::PTR_W-1:0]           r_wptr [tsmf_pkg::CHANNELS];
    logic [tsmf_pkg::CNT_W-1:0]           r_fill [tsmf_pkg::CHANNELS];
    logic [tsmf_pkg::CNT_W-1:0]           r_n;
    logic [tsmf_pkg::CNT_W-1:0]           r_k, n_k;
    logic [tsmf_pkg::ADDR_W-1:0]          r_base;
    logic [tsmf_pkg::FILT_W-1:0]          r_res;
    logic                                 r_avg;
    logic                                 r_o_valid;
    logic [tsmf_pkg::FILT_W-1:0]          r_o_data;
    logic                                 r_o_user;

    logic signed [tsmf_pkg::SAMPLE_W-1:0] sample;
    logic [tsmf_pkg::CHAN_W-1:0]          channel;
    logic [tsmf_pkg::CH_IDX_W-1:0]        ch_idx;
    logic                                 accept;
    logic                                 in_range;
    logic [tsmf_pkg::PTR_W-1:0]           wptr;
    logic [tsmf_pkg::CNT_W-1:0]           fill;
    logic [tsmf_pkg::CNT_W-1:0]           n_fill;
    logic [tsmf_pkg::ADDR_W-1:0]          base;
    logic                                 out_free;
    logic                                 rd_en;

    logic signed [tsmf_pkg::SUM_W-1:0]    sum;
    logic signed [tsmf_pkg::SAMPLE_W-1:0] lo;
    logic signed [tsmf_pkg::SAMPLE_W-1:0] hi;
    logic signed [tsmf_pkg::TRIM_W-1:0]   trim;
    logic [tsmf_pkg::TRIM_W-1:0]          trim_mag;

    tsmf_pkg::t_div_req                   div_req;
    tsmf_pkg::t_div_rsp                   div_rsp;

    assign sample   = i_s_tdata[tsmf_pkg::SAMPLE_W-1:0];
    assign channel  = i_s_tdata[tsmf_pkg::SAMPLE_W +: tsmf_pkg::CHAN_W];
    assign ch_idx   = channel[tsmf_pkg::CH_IDX_W-1:0];
    assign in_range = {1'b0, channel} < (tsmf_pkg::CHAN_W + 1)'(tsmf_pkg::CHANNELS);
    assign accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign wptr     = r_wptr[ch_idx];
    assign fill     = r_fill[ch_idx];
    assign n_fill   = (fill < tsmf_pkg::CNT_W'(tsmf_pkg::WINDOW)) ? fill + 1'b1 : fill;
    assign base     = tsmf_pkg::ADDR_W'(ch_idx) * tsmf_pkg::ADDR_W'(tsmf_pkg::WINDOW);
    assign out_free = !r_o_valid || i_m_tready;
    assign rd_en    = r_state == ST_SCAN;

    tsmf_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && in_range),
        .i_wr_addr  (base + tsmf_pkg::ADDR_W'(wptr)),
        .i_wr_data  (sample),
        .i_rd_en    (rd_en),
        .i_rd_first (r_k == '0),
        .i_rd_addr  (r_base + tsmf_pkg::ADDR_W'(r_k)),
        .o_sum      (sum),
        .o_lo       (lo),
        .o_hi       (hi)
    );

    assign trim = tsmf_pkg::TRIM_W'(sum)
                - tsmf_pkg::TRIM_W'(lo)
                - tsmf_pkg::TRIM_W'(hi);
    assign trim_mag = trim[tsmf_pkg::TRIM_W-1] ? (~trim + 1'b1) : trim;

    assign div_req.start    = r_state == ST_START;
    assign div_req.neg      = trim[tsmf_pkg::TRIM_W-1];
    assign div_req.dividend = {trim_mag, {tsmf_pkg::Q_SHIFT{1'b0}}};
    assign div_req.divisor  = r_n - tsmf_pkg::CNT_W'(2);

    tsmf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                n_k = '0;
                if (accept) begin
                    if (in_range && (n_fill >= tsmf_pkg::CNT_W'(tsmf_pkg::MIN_FILL))) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == r_n - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < tsmf_pkg::CHANNELS; i++) begin
                r_wptr[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (accept && in_range) begin
                r_wptr[ch_idx] <= (wptr == tsmf_pkg::PTR_W'(tsmf_pkg::WINDOW - 1)) ?
                                  '0 : wptr + 1'b1;
                r_fill[ch_idx] <= n_fill;
            end
            if ((r_state == ST_OUT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= n_fill;
            r_base <= base;
            r_res  <= {sample, {tsmf_pkg::Q_SHIFT{1'b0}}};
            r_avg  <= 1'b0;
        end else if ((r_state == ST_DIV) && div_rsp.done) begin
            r_res  <= div_rsp.quotient;
            r_avg  <= 1'b1;
        end
        if ((r_state == ST_OUT) && out_free) begin
            r_o_data <= r_res;
            r_o_user <= r_avg;
        end
    end

    assign o_s_tready = r_state == ST_IDLE;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

endmodule
